### src/lrd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrd_pkg
// Shared constants and types for the dotted Bresenham line rasterizer.
// ----------------------------------------------------------------------------
package lrd_pkg;

    localparam int COORD_BITS = 12;
    localparam int ERR_BITS   = COORD_BITS + 3;

    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] cur_x;
        logic signed [COORD_BITS-1:0] cur_y;
        logic signed [COORD_BITS-1:0] major_end;
        logic signed [ERR_BITS-1:0]   decision;
        logic signed [ERR_BITS-1:0]   inc_straight;
        logic signed [ERR_BITS-1:0]   inc_diagonal;
        logic                         steep;
        logic                         minor_down;
        logic                         fin;
    } setup_t;

    typedef struct packed {
        logic                         valid_res;
        logic signed [COORD_BITS-1:0] pixel_x;
        logic signed [COORD_BITS-1:0] pixel_y;
        logic                         visible;
        logic                         last;
    } result_t;

endpackage

### src/lrd_setup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrd_setup
// Endpoint ordering and Bresenham term setup for a start command.
// ----------------------------------------------------------------------------
module lrd_setup
    import lrd_pkg::*;
(
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,
    output setup_t                       setup
);

    logic signed [COORD_BITS:0] diff_x;
    logic signed [COORD_BITS:0] diff_y;
    logic        [COORD_BITS:0] abs_x;
    logic        [COORD_BITS:0] abs_y;
    logic        [COORD_BITS:0] dmaj;
    logic        [COORD_BITS:0] dmin;
    logic signed [ERR_BITS-1:0] dmaj_ext;
    logic signed [ERR_BITS-1:0] dmin_x2;
    logic signed [ERR_BITS-1:0] dmaj_x2;
    logic                       steep;

    assign diff_x = {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
    assign diff_y = {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};
    assign abs_x  = diff_x[COORD_BITS] ? -diff_x : diff_x;
    assign abs_y  = diff_y[COORD_BITS] ? -diff_y : diff_y;
    assign steep  = abs_y > abs_x;
    assign dmaj   = steep ? abs_y : abs_x;
    assign dmin   = steep ? abs_x : abs_y;

    assign dmaj_ext = {2'b00, dmaj};
    assign dmin_x2  = {1'b0, dmin, 1'b0};
    assign dmaj_x2  = {1'b0, dmaj, 1'b0};

    always_comb
    begin
        setup.steep        = steep;
        setup.inc_straight = dmin_x2;
        setup.inc_diagonal = dmin_x2 - dmaj_x2;
        setup.decision     = dmin_x2 - dmaj_ext;
        setup.fin          = (dmaj == '0);
        if (!steep)
        begin
            if (diff_x[COORD_BITS])
            begin
                setup.cur_x      = end_x;
                setup.cur_y      = end_y;
                setup.major_end  = start_x;
                setup.minor_down = !diff_y[COORD_BITS] && (diff_y != '0);
            end
            else
            begin
                setup.cur_x      = start_x;
                setup.cur_y      = start_y;
                setup.major_end  = end_x;
                setup.minor_down = diff_y[COORD_BITS];
            end
        end
        else
        begin
            if (diff_y[COORD_BITS])
            begin
                setup.cur_x      = end_x;
                setup.cur_y      = end_y;
                setup.major_end  = start_y;
                setup.minor_down = !diff_x[COORD_BITS] && (diff_x != '0);
            end
            else
            begin
                setup.cur_x      = start_x;
                setup.cur_y      = start_y;
                setup.major_end  = end_y;
                setup.minor_down = diff_x[COORD_BITS];
            end
        end
    end

endmodule

### src/lrd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrd_core
// Line state registers and the per-pixel Bresenham step.
// ----------------------------------------------------------------------------
module lrd_core
    import lrd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  logic    command,
    input  logic    dotted,
    input  setup_t  setup,
    output result_t result
);

    logic signed [COORD_BITS-1:0] cur_x_reg,        cur_x_next;
    logic signed [COORD_BITS-1:0] cur_y_reg,        cur_y_next;
    logic signed [COORD_BITS-1:0] major_end_reg,    major_end_next;
    logic signed [ERR_BITS-1:0]   decision_reg,     decision_next;
    logic signed [ERR_BITS-1:0]   inc_straight_reg, inc_straight_next;
    logic signed [ERR_BITS-1:0]   inc_diagonal_reg, inc_diagonal_next;
    logic                         steep_reg,        steep_next;
    logic                         minor_down_reg,   minor_down_next;
    logic                         dot_phase_reg,    dot_phase_next;
    logic                         dotted_mode_reg,  dotted_mode_next;
    logic                         active_reg,       active_next;

    logic signed [COORD_BITS-1:0] minor_step;
    logic signed [COORD_BITS-1:0] minor_delta;
    logic                         diag;
    logic                         fin;

    assign diag        = !decision_reg[ERR_BITS-1];
    assign minor_step  = minor_down_reg ? '1 : COORD_BITS'(1);
    assign minor_delta = diag ? minor_step : '0;

    always_comb
    begin
        cur_x_next        = cur_x_reg;
        cur_y_next        = cur_y_reg;
        major_end_next    = major_end_reg;
        decision_next     = decision_reg;
        inc_straight_next = inc_straight_reg;
        inc_diagonal_next = inc_diagonal_reg;
        steep_next        = steep_reg;
        minor_down_next   = minor_down_reg;
        dot_phase_next    = dot_phase_reg;
        dotted_mode_next  = dotted_mode_reg;
        active_next       = active_reg;
        fin               = 1'b0;
        result            = '0;

        if (command == CMD_START)
        begin
            cur_x_next        = setup.cur_x;
            cur_y_next        = setup.cur_y;
            major_end_next    = setup.major_end;
            decision_next     = setup.decision;
            inc_straight_next = setup.inc_straight;
            inc_diagonal_next = setup.inc_diagonal;
            steep_next        = setup.steep;
            minor_down_next   = setup.minor_down;
            dot_phase_next    = 1'b0;
            dotted_mode_next  = dotted;
            active_next       = !setup.fin;
            result.valid_res  = 1'b1;
            result.pixel_x    = setup.cur_x;
            result.pixel_y    = setup.cur_y;
            result.visible    = 1'b1;
            result.last       = setup.fin;
        end
        else if (active_reg)
        begin
            if (steep_reg)
            begin
                cur_y_next = cur_y_reg + COORD_BITS'(1);
                cur_x_next = cur_x_reg + minor_delta;
                fin        = (cur_y_next == major_end_reg);
            end
            else
            begin
                cur_x_next = cur_x_reg + COORD_BITS'(1);
                cur_y_next = cur_y_reg + minor_delta;
                fin        = (cur_x_next == major_end_reg);
            end
            decision_next    = decision_reg + (diag ? inc_diagonal_reg : inc_straight_reg);
            dot_phase_next   = !dot_phase_reg;
            active_next      = !fin;
            result.valid_res = 1'b1;
            result.pixel_x   = cur_x_next;
            result.pixel_y   = cur_y_next;
            result.visible   = !dotted_mode_reg || dot_phase_reg;
            result.last      = fin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg        <= '0;
            cur_y_reg        <= '0;
            major_end_reg    <= '0;
            decision_reg     <= '0;
            inc_straight_reg <= '0;
            inc_diagonal_reg <= '0;
            steep_reg        <= 1'b0;
            minor_down_reg   <= 1'b0;
            dot_phase_reg    <= 1'b0;
            dotted_mode_reg  <= 1'b0;
            active_reg       <= 1'b0;
        end
        else if (fire)
        begin
            cur_x_reg        <= cur_x_next;
            cur_y_reg        <= cur_y_next;
            major_end_reg    <= major_end_next;
            decision_reg     <= decision_next;
            inc_straight_reg <= inc_straight_next;
            inc_diagonal_reg <= inc_diagonal_next;
            steep_reg        <= steep_next;
            minor_down_reg   <= minor_down_next;
            dot_phase_reg    <= dot_phase_next;
            dotted_mode_reg  <= dotted_mode_next;
            active_reg       <= active_next;
        end
    end

endmodule

### src/line_rasterizer_dotted.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_rasterizer_dotted
// Bresenham line generator for all octants with optional dotted output.
//
//   channel  direction  handshake              fields
//   cmd      in         cmd_valid/cmd_stall    command start_x start_y end_x
//                                              end_y dotted
//   pix      out        pix_valid/pix_stall    valid_res pixel_x pixel_y
//                                              visible last
//
// One command transfer per cycle unless stalled, one result per command.
// A command passes through the input register, then the result register,
// before its result is offered on pix.
// The step and setup logic sits between the two registers.
// Reset clears the line state and both register valids; no line is active.
// A stalled result holds; cmd_stall rises only while a result waits and
// another command is already registered.
// ----------------------------------------------------------------------------
module line_rasterizer_dotted
    import lrd_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    output logic                         cmd_stall,
    input  logic                         command,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,
    input  logic                         dotted,
    output logic                         pix_valid,
    input  logic                         pix_stall,
    output logic                         valid_res,
    output logic signed [COORD_BITS-1:0] pixel_x,
    output logic signed [COORD_BITS-1:0] pixel_y,
    output logic                         visible,
    output logic                         last
);

    logic                         in_vld_reg;
    logic                         command_reg;
    logic signed [COORD_BITS-1:0] start_x_reg;
    logic signed [COORD_BITS-1:0] start_y_reg;
    logic signed [COORD_BITS-1:0] end_x_reg;
    logic signed [COORD_BITS-1:0] end_y_reg;
    logic                         dotted_reg;
    logic                         out_vld_reg;
    result_t                      res_reg;
    result_t                      res_next;
    setup_t                       setup;
    logic                         fire;
    logic                         cmd_take;

    assign fire      = in_vld_reg && (!out_vld_reg || !pix_stall);
    assign cmd_stall = in_vld_reg && !fire;
    assign cmd_take  = cmd_valid && !cmd_stall;

    lrd_setup u_setup
    (
        .start_x (start_x_reg),
        .start_y (start_y_reg),
        .end_x   (end_x_reg),
        .end_y   (end_y_reg),
        .setup   (setup)
    );

    lrd_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .command (command_reg),
        .dotted  (dotted_reg),
        .setup   (setup),
        .result  (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cmd_take)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_vld_reg <= 1'b0;
            end
            if (fire)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (!pix_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            command_reg <= command;
            start_x_reg <= start_x;
            start_y_reg <= start_y;
            end_x_reg   <= end_x;
            end_y_reg   <= end_y;
            dotted_reg  <= dotted;
        end
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    assign pix_valid = out_vld_reg;
    assign valid_res = res_reg.valid_res;
    assign pixel_x   = res_reg.pixel_x;
    assign pixel_y   = res_reg.pixel_y;
    assign visible   = res_reg.visible;
    assign last      = res_reg.last;

endmodule

### src/lrd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrd_checker
// Port-level checks for the line rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module lrd_checker
    import lrd_pkg::*;
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         cmd_stall,
    input logic                         pix_valid,
    input logic                         pix_stall,
    input logic                         valid_res,
    input logic signed [COORD_BITS-1:0] pixel_x,
    input logic signed [COORD_BITS-1:0] pixel_y,
    input logic                         visible,
    input logic                         last
);

    a_pix_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && pix_stall |=> pix_valid)
        else $error("pix_valid dropped while stalled");

    a_pix_stable: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && pix_stall |=> $stable({valid_res, pixel_x, pixel_y, visible, last}))
        else $error("stalled result changed");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> pix_valid && pix_stall)
        else $error("command stalled without a waiting result");

    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !valid_res |-> pixel_x == '0 && pixel_y == '0 && !visible && !last)
        else $error("invalid result carries nonzero fields");

endmodule

bind line_rasterizer_dotted lrd_checker u_lrd_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_stall (cmd_stall),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .valid_res (valid_res),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .visible   (visible),
    .last      (last)
);

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dotted Bresenham line rasterizer.
//
// A tracker class keeps its own copy of the line state. It predicts one pixel
// result for every command transfer and checks each pixel transfer against the
// oldest prediction. Stimulus has two parts. The first is a short directed
// part: no active line, a single-point line, the coordinate extremes, a restart
// while a line is active, and lines in several octants. The second is random
// short lines, mostly run to the end, mixed with full-range starts and
// stray advances. Both sides insert random gaps. The pixel side holds off once
// for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
import lrd_pkg::*;

class raster_tracker;
    int pos_x, pos_y, major_stop;
    int err_term, err_flat, err_diag;
    bit y_major, minor_neg, odd_pixel, dash_mode, drawing;
    result_t pending_pixels[$];
    int mismatches;

    function new();
        pos_x = 0; pos_y = 0; major_stop = 0;
        err_term = 0; err_flat = 0; err_diag = 0;
        y_major = 0; minor_neg = 0; odd_pixel = 0; dash_mode = 0; drawing = 0;
        mismatches = 0;
    endfunction

    function int pending();
        return pending_pixels.size();
    endfunction

    function void take_command(input logic cmd,
                               input logic signed [COORD_BITS-1:0] sx, sy, ex, ey,
                               input logic dot);
        result_t px;
        int x1, y1, x2, y2, dx, dy, dmaj, dmin;
        bit diag, fin;
        px = '0;
        if (cmd == CMD_START)
        begin
            x1 = sx; y1 = sy; x2 = ex; y2 = ey;
            dx = (x2 > x1) ? x2 - x1 : x1 - x2;
            dy = (y2 > y1) ? y2 - y1 : y1 - y2;
            dash_mode = dot;
            y_major = dy > dx;
            odd_pixel = 0;
            if (!y_major)
            begin
                dmaj = dx; dmin = dy;
                if (x1 > x2)
                begin
                    pos_x = x2; pos_y = y2; major_stop = x1; minor_neg = y1 < y2;
                end
                else
                begin
                    pos_x = x1; pos_y = y1; major_stop = x2; minor_neg = y2 < y1;
                end
            end
            else
            begin
                dmaj = dy; dmin = dx;
                if (y1 > y2)
                begin
                    pos_x = x2; pos_y = y2; major_stop = y1; minor_neg = x1 < x2;
                end
                else
                begin
                    pos_x = x1; pos_y = y1; major_stop = y2; minor_neg = x2 < x1;
                end
            end
            err_term = 2 * dmin - dmaj;
            err_flat = 2 * dmin;
            err_diag = 2 * (dmin - dmaj);
            fin = ((y_major ? pos_y : pos_x) == major_stop);
            drawing = !fin;
            px.visible = 1'b1;
        end
        else if (!drawing)
        begin
            // advance with no line: all-zero result
            pending_pixels.push_back(px);
            return;
        end
        else
        begin
            diag = (err_term >= 0);
            if (y_major)
            begin
                pos_y += 1;
                if (diag) pos_x += minor_neg ? -1 : 1;
            end
            else
            begin
                pos_x += 1;
                if (diag) pos_y += minor_neg ? -1 : 1;
            end
            err_term += diag ? err_diag : err_flat;
            odd_pixel = !odd_pixel;
            px.visible = !dash_mode || !odd_pixel;
            fin = ((y_major ? pos_y : pos_x) == major_stop);
            if (fin) drawing = 0;
        end
        px.valid_res = 1'b1;
        px.pixel_x = pos_x[COORD_BITS-1:0];
        px.pixel_y = pos_y[COORD_BITS-1:0];
        px.last = fin;
        pending_pixels.push_back(px);
    endfunction

    function void check_field(input string name,
                              input logic [COORD_BITS-1:0] want,
                              input logic [COORD_BITS-1:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, $signed(want), $signed(got));
            mismatches++;
        end
    endfunction

    function void match_pixel(input result_t got);
        result_t want;
        if (pending_pixels.size() == 0)
        begin
            $error("pixel transfer with no command waiting for it");
            mismatches++;
            return;
        end
        want = pending_pixels.pop_front();
        check_field("valid_res", COORD_BITS'(want.valid_res), COORD_BITS'(got.valid_res));
        check_field("pixel_x", want.pixel_x, got.pixel_x);
        check_field("pixel_y", want.pixel_y, got.pixel_y);
        check_field("visible", COORD_BITS'(want.visible), COORD_BITS'(got.visible));
        check_field("last", COORD_BITS'(want.last), COORD_BITS'(got.last));
    endfunction
endclass

module tb_top;

    localparam int CMAX        = (1 << (COORD_BITS - 1)) - 1;
    localparam int CMIN        = -CMAX - 1;
    localparam int N_DIRECTED  = 25;
    localparam int N_RANDOM    = 1700;
    localparam int IDLE_LIMIT  = 4000;
    localparam int HOLD_AFTER  = 400;
    localparam int HOLD_CYCLES = 250;

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_stall;
    logic command;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic dotted;
    logic pix_valid;
    logic pix_stall;
    logic valid_res;
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic visible;
    logic last;

    raster_tracker line_sb = new();
    int cmd_count = 0;
    int pix_count = 0;
    bit tx_steady = 0;

    line_rasterizer_dotted DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .command   (command),
        .start_x   (start_x),
        .start_y   (start_y),
        .end_x     (end_x),
        .end_y     (end_y),
        .dotted    (dotted),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .valid_res (valid_res),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .visible   (visible),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        if (tx_steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_cmd(input logic cmd,
                            input logic signed [COORD_BITS-1:0] sx, sy, ex, ey,
                            input logic dot);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        command   <= cmd;
        start_x   <= sx;
        start_y   <= sy;
        end_x     <= ex;
        end_y     <= ey;
        dotted    <= dot;
        do
            @(posedge clk);
        while (cmd_stall !== 1'b0);
        line_sb.take_command(cmd, sx, sy, ex, ey, dot);
        cmd_count++;
    endtask

    // advance fields other than command carry random junk
    task automatic advance(input int n);
        repeat (n)
            send_cmd(CMD_ADVANCE, COORD_BITS'($urandom), COORD_BITS'($urandom),
                     COORD_BITS'($urandom), COORD_BITS'($urandom), 1'($urandom));
    endtask

    task automatic draw_line(input int x1, y1, x2, y2, input logic dot, input int n_adv);
        send_cmd(CMD_START, COORD_BITS'(x1), COORD_BITS'(y1),
                 COORD_BITS'(x2), COORD_BITS'(y2), dot);
        advance(n_adv);
    endtask

    task automatic wait_drained();
        cmd_valid <= 1'b0;
        do
            @(posedge clk);
        while (line_sb.pending() != 0);
    endtask

    // endpoint pair along one axis, mostly short, sometimes hugging an edge
    task automatic pick_span(output int a, output int b, input int maxlen);
        int d;
        if ($urandom_range(0, 4) == 0)
            a = $urandom_range(0, 1) ? CMAX - int'($urandom_range(0, 15))
                                     : CMIN + int'($urandom_range(0, 15));
        else
            a = int'($urandom_range(0, 2 * CMAX + 1)) + CMIN;
        d = int'($urandom_range(0, 2 * maxlen)) - maxlen;
        b = a + d;
        if (b > CMAX || b < CMIN) b = a - d;
    endtask

    function automatic int rand_coord();
        return int'($urandom_range(0, 2 * CMAX + 1)) + CMIN;
    endfunction

    // pixel side: random stall bursts, one long hold-off
    initial
    begin
        int run_len;
        bit stall_val;
        bit held;
        held = 0;
        pix_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (!held && pix_count >= HOLD_AFTER)
            begin
                held = 1;
                stall_val = 1;
                run_len = HOLD_CYCLES;
            end
            else if ($urandom_range(0, 99) < 40)
            begin
                stall_val = 0;
                run_len = $urandom_range(1, 40);
            end
            else
            begin
                stall_val = 1;
                run_len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                        : $urandom_range(10, 40);
            end
            repeat (run_len)
            begin
                @(posedge clk);
                if (pix_valid === 1'b1 && pix_stall == 1'b0)
                begin
                    line_sb.match_pixel({valid_res, pixel_x, pixel_y, visible, last});
                    pix_count++;
                end
                pix_stall <= stall_val;
            end
        end
    end

    initial
    begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_valid === 1'b1 && cmd_stall === 1'b0) ||
                (pix_valid === 1'b1 && pix_stall === 1'b0))
                idle = 0;
            else
                idle++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int x1, y1, x2, y2, major, n, sel, maxlen;
        rst_n     <= 1'b0;
        cmd_valid <= 1'b0;
        command   <= CMD_START;
        start_x   <= '0;
        start_y   <= '0;
        end_x     <= '0;
        end_y     <= '0;
        dotted    <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed
        advance(1);
        draw_line(5, -7, 5, -7, 1'b1, 1);
        draw_line(CMIN, CMIN, CMAX, CMAX, 1'b0, 2);
        draw_line(CMAX, CMIN, CMIN, CMAX, 1'b1, 1);
        draw_line(0, 0, 4, -2, 1'b1, 5);
        draw_line(3, 1, -1, 6, 1'b0, 5);
        draw_line(2, 2, -2, -2, 1'b1, 4);
        wait_drained();

        // random
        while (cmd_count < N_DIRECTED + N_RANDOM)
        begin
            tx_steady = ($urandom_range(0, 3) == 0);
            sel = $urandom_range(0, 99);
            if (sel < 78)
            begin
                maxlen = ($urandom_range(0, 9) == 0) ? 60 : 10;
                pick_span(x1, x2, maxlen);
                pick_span(y1, y2, maxlen);
                major = (x2 > x1) ? x2 - x1 : x1 - x2;
                if (((y2 > y1) ? y2 - y1 : y1 - y2) > major)
                    major = (y2 > y1) ? y2 - y1 : y1 - y2;
                if ($urandom_range(0, 6) == 0)
                    n = $urandom_range(0, major);
                else
                    n = major + $urandom_range(0, 2);
                draw_line(x1, y1, x2, y2, 1'($urandom_range(0, 1)), n);
            end
            else if (sel < 88)
                draw_line(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                          1'($urandom_range(0, 1)), $urandom_range(0, 3));
            else if (sel < 97)
                advance($urandom_range(1, 3));
            else
                wait_drained();
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (line_sb.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### sim.f
src/lrd_pkg.sv
src/lrd_setup.sv
src/lrd_core.sv
src/line_rasterizer_dotted.sv
src/lrd_checker.sv
verif/tb_top.sv
